FILE: hw/rtl/qoid_pkg.sv
// Shared types, codes and constants for the QOI stream decoder.
// No dependencies; every other file but qoid_ram imports this package.
package qoid_pkg;

    localparam int INDEX_ENTRIES_DEF = 64;

    localparam logic [7:0] OP_RGB_BYTE  = 8'hFE;
    localparam logic [7:0] OP_RGBA_BYTE = 8'hFF;
    localparam logic [7:0] CH_RGB       = 8'd3;
    localparam logic [7:0] CH_RGBA      = 8'd4;
    localparam logic [31:0] RGB_ZERO_OPAQUE = 32'h0000_00FF;

    localparam logic [7:0] MAGIC [4] = '{8'h71, 8'h6F, 8'h69, 8'h66};
    localparam logic [3:0] HDR_LAST_POS = 4'd13;
    localparam logic [3:0] HDR_CH_POS   = 4'd12;
    localparam logic [3:0] HDR_DIM_POS  = 4'd4;
    localparam logic [3:0] END_LAST_POS = 4'd7;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_OPCODE,
        PH_PAYLOAD,
        PH_END
    } phase_t;

    typedef enum logic [2:0] {
        KIND_PIXEL,
        KIND_HDR_OK,
        KIND_END_OK,
        KIND_END_BAD,
        KIND_BAD_MAGIC,
        KIND_BAD_DIMS,
        KIND_RUN_OVF,
        KIND_TRUNC
    } kind_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_SOF,
        OP_HDR,
        OP_MUL,
        OP_HDR_OK,
        OP_GO_IDLE,
        OP_SET_OP,
        OP_RD_IDX,
        OP_RUN_START,
        OP_PAY_SHIFT,
        OP_PUT,
        OP_END_STEP
    } op_t;

    typedef enum logic [1:0] {
        SRC_DIFF,
        SRC_INDEX,
        SRC_RUN,
        SRC_PAYLOAD
    } src_t;

    typedef enum logic [1:0] {
        CL_PAYLOAD,
        CL_INDEX,
        CL_DIFF,
        CL_RUN
    } class_t;

    typedef enum logic [2:0] {
        ST_IN,
        ST_SOF,
        ST_EXEC,
        ST_HCHK,
        ST_IDX,
        ST_RUN,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t   op;
        src_t  src;
        logic  emit;
        kind_t kind;
        logic  last;
    } ctrl_cmd_t;

    typedef struct packed {
        phase_t     phase;
        logic       sof;
        logic [3:0] pos;
        logic       magic_ok;
        logic       is_q;
        class_t     cls;
        logic       pay_done;
        logic       end_done;
        logic       end_bad;
        logic       dims_bad;
        logic       left_zero;
        logic       run_last;
    } dp_stat_t;

endpackage

FILE: hw/rtl/qoid_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qoid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: hw/rtl/qoid_dp.sv
// Datapath: byte latch, header and chunk registers, pixel math, color index, result register.
// Depends on qoid_pkg and qoid_ram.
module qoid_dp #(
    parameter int INDEX_ENTRIES = qoid_pkg::INDEX_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          s_data_byte,
    input  logic                s_start_of_file,
    input  qoid_pkg::ctrl_cmd_t cmd,
    output qoid_pkg::dp_stat_t  stat,
    output logic [2:0]          m_kind,
    output logic [7:0]          m_red,
    output logic [7:0]          m_green,
    output logic [7:0]          m_blue,
    output logic [7:0]          m_alpha,
    output logic                m_last,
    output logic [31:0]         m_image_width,
    output logic [31:0]         m_image_height,
    output logic [7:0]          m_channel_count,
    output logic [7:0]          m_color_space
);
    import qoid_pkg::*;

    localparam int IDX_W = $clog2(INDEX_ENTRIES);

    logic [7:0]  byte_reg;
    logic        sof_reg;
    phase_t      phase_reg;
    logic [3:0]  pos_reg;
    logic [63:0] hdr_reg;
    logic [7:0]  chop_reg;
    logic [31:0] pay_reg;
    logic [31:0] left_reg;
    logic [31:0] prev_reg;
    logic        mis_reg;
    logic        ovf_reg;
    logic [31:0] prodlo_reg;
    logic [6:0]  run_reg;
    logic [INDEX_ENTRIES-1:0] valid_reg;
    logic        vhit_reg;

    logic [2:0]  kind_reg;
    logic [31:0] px_out_reg;
    logic        last_reg;
    logic [31:0] w_out_reg;
    logic [31:0] h_out_reg;
    logic [7:0]  ch_out_reg;
    logic [7:0]  cs_out_reg;

    logic [31:0] ram_rdata;
    logic [31:0] pay_next;
    logic [31:0] px;
    logic [31:0] idx_px;
    logic [7:0]  pr, pg, pb, pa;
    logic [7:0]  dg, dr, db;
    logic [9:0]  hash_sum;
    logic [63:0] product;
    logic [3:0]  need;
    logic [7:0]  end_exp;
    logic        do_put;

    assign pr = prev_reg[31:24];
    assign pg = prev_reg[23:16];
    assign pb = prev_reg[15:8];
    assign pa = prev_reg[7:0];
    assign pay_next = {pay_reg[23:0], byte_reg};
    assign idx_px = vhit_reg ? ram_rdata : '0;
    assign product = {32'd0, hdr_reg[63:32]} * {32'd0, hdr_reg[31:0]};

    always_comb begin
        dg = {2'b00, chop_reg[5:0]} + 8'd224;
        dr = dg + {4'd0, byte_reg[7:4]} + 8'd248;
        db = dg + {4'd0, byte_reg[3:0]} + 8'd248;
        case (cmd.src)
            SRC_DIFF: px = {pr + {6'd0, byte_reg[5:4]} + 8'd254,
                            pg + {6'd0, byte_reg[3:2]} + 8'd254,
                            pb + {6'd0, byte_reg[1:0]} + 8'd254, pa};
            SRC_INDEX: px = idx_px;
            SRC_RUN: px = prev_reg;
            SRC_PAYLOAD: begin
                if (chop_reg == OP_RGB_BYTE) begin
                    px = {pay_next[23:0], pa};
                end else if (chop_reg == OP_RGBA_BYTE) begin
                    px = pay_next;
                end else begin
                    px = {pr + dr, pg + dg, pb + db, pa};
                end
            end
            default: px = prev_reg;
        endcase
        hash_sum = {2'b00, px[31:24]} * 10'd3 + {2'b00, px[23:16]} * 10'd5
                 + {2'b00, px[15:8]} * 10'd7 + {2'b00, px[7:0]} * 10'd11;
        if (chop_reg == OP_RGB_BYTE) begin
            need = 4'd3;
        end else if (chop_reg == OP_RGBA_BYTE) begin
            need = 4'd4;
        end else begin
            need = 4'd1;
        end
        end_exp = (pos_reg == END_LAST_POS) ? 8'd1 : 8'd0;
    end

    assign do_put = (cmd.op == OP_PUT);

    qoid_ram #(
        .WIDTH(32),
        .DEPTH(INDEX_ENTRIES)
    ) u_index (
        .aclk  (aclk),
        .we    (do_put),
        .waddr (hash_sum[IDX_W-1:0]),
        .wdata (px),
        .raddr (byte_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        stat.phase = phase_reg;
        stat.sof = sof_reg;
        stat.pos = pos_reg;
        stat.magic_ok = (byte_reg == MAGIC[pos_reg[1:0]]);
        stat.is_q = (byte_reg == MAGIC[0]);
        if (byte_reg == OP_RGB_BYTE || byte_reg == OP_RGBA_BYTE
            || byte_reg[7:6] == 2'b10) begin
            stat.cls = CL_PAYLOAD;
        end else if (byte_reg[7:6] == 2'b00) begin
            stat.cls = CL_INDEX;
        end else if (byte_reg[7:6] == 2'b01) begin
            stat.cls = CL_DIFF;
        end else begin
            stat.cls = CL_RUN;
        end
        stat.pay_done = (pos_reg + 4'd1) >= need;
        stat.end_done = (pos_reg == END_LAST_POS);
        stat.end_bad = mis_reg || (byte_reg != end_exp);
        stat.dims_bad = (hdr_reg[63:32] == 32'd0) || (hdr_reg[31:0] == 32'd0)
                     || (chop_reg < CH_RGB) || (chop_reg > CH_RGBA) || ovf_reg;
        stat.left_zero = (left_reg == 32'd0);
        stat.run_last = (run_reg == 7'd1);
    end

    always_ff @(posedge aclk) begin
        vhit_reg <= valid_reg[byte_reg[IDX_W-1:0]];
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            valid_reg <= '0;
            mis_reg   <= 1'b0;
            left_reg  <= '0;
            prev_reg  <= RGB_ZERO_OPAQUE;
        end else begin
            case (cmd.op)
                OP_LATCH: begin
                    byte_reg <= s_data_byte;
                    sof_reg  <= s_start_of_file;
                end
                OP_SOF: begin
                    phase_reg <= PH_HEADER;
                    pos_reg   <= '0;
                    hdr_reg   <= '0;
                    chop_reg  <= '0;
                    pay_reg   <= '0;
                end
                OP_HDR: begin
                    pos_reg <= pos_reg + 4'd1;
                    if (pos_reg == HDR_CH_POS) begin
                        chop_reg <= byte_reg;
                    end else if (pos_reg >= HDR_DIM_POS) begin
                        hdr_reg <= {hdr_reg[55:0], byte_reg};
                    end
                end
                OP_MUL: begin
                    ovf_reg    <= (product[63:32] != 32'd0);
                    prodlo_reg <= product[31:0];
                end
                OP_HDR_OK: begin
                    left_reg  <= prodlo_reg;
                    prev_reg  <= RGB_ZERO_OPAQUE;
                    valid_reg <= '0;
                    chop_reg  <= '0;
                    pay_reg   <= '0;
                    pos_reg   <= '0;
                    phase_reg <= PH_OPCODE;
                end
                OP_GO_IDLE: phase_reg <= PH_IDLE;
                OP_SET_OP: begin
                    chop_reg  <= byte_reg;
                    pay_reg   <= '0;
                    pos_reg   <= '0;
                    phase_reg <= PH_PAYLOAD;
                end
                OP_RUN_START: run_reg <= {1'b0, byte_reg[5:0]} + 7'd1;
                OP_PAY_SHIFT: begin
                    pay_reg <= pay_next;
                    pos_reg <= pos_reg + 4'd1;
                end
                OP_PUT: begin
                    valid_reg[hash_sum[IDX_W-1:0]] <= 1'b1;
                    prev_reg <= px;
                    left_reg <= left_reg - 32'd1;
                    if (cmd.src == SRC_RUN) begin
                        run_reg <= run_reg - 7'd1;
                    end
                    if (cmd.src == SRC_PAYLOAD) begin
                        pay_reg <= pay_next;
                    end
                    if (left_reg == 32'd1) begin
                        phase_reg <= PH_END;
                        pos_reg   <= '0;
                        mis_reg   <= 1'b0;
                    end else if (cmd.src == SRC_PAYLOAD) begin
                        phase_reg <= PH_OPCODE;
                        pos_reg   <= '0;
                    end
                end
                OP_END_STEP: begin
                    mis_reg <= stat.end_bad;
                    if (stat.end_done) begin
                        phase_reg <= PH_IDLE;
                        pos_reg   <= '0;
                    end else begin
                        pos_reg <= pos_reg + 4'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            kind_reg   <= cmd.kind;
            last_reg   <= cmd.last;
            px_out_reg <= (cmd.kind == KIND_PIXEL) ? px : '0;
            if (cmd.kind == KIND_HDR_OK) begin
                w_out_reg  <= hdr_reg[63:32];
                h_out_reg  <= hdr_reg[31:0];
                ch_out_reg <= chop_reg;
                cs_out_reg <= byte_reg;
            end else begin
                w_out_reg  <= '0;
                h_out_reg  <= '0;
                ch_out_reg <= '0;
                cs_out_reg <= '0;
            end
        end
    end

    assign m_kind          = kind_reg;
    assign m_red           = px_out_reg[31:24];
    assign m_green         = px_out_reg[23:16];
    assign m_blue          = px_out_reg[15:8];
    assign m_alpha         = px_out_reg[7:0];
    assign m_last          = last_reg;
    assign m_image_width   = w_out_reg;
    assign m_image_height  = h_out_reg;
    assign m_channel_count = ch_out_reg;
    assign m_color_space   = cs_out_reg;
endmodule

FILE: hw/rtl/qoid_ctrl.sv
// Controller: sequences byte accept, decode, index read, runs and result handoff.
// Depends on qoid_pkg.
module qoid_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  qoid_pkg::dp_stat_t  stat,
    output qoid_pkg::ctrl_cmd_t cmd
);
    import qoid_pkg::*;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IN;
            ret_reg   <= ST_IN;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '{op: OP_NONE, src: SRC_RUN, emit: 1'b0, kind: KIND_PIXEL, last: 1'b1};
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_IN: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_LATCH;
                    state_next = ST_SOF;
                end
            end
            ST_SOF: begin
                state_next = ST_EXEC;
                if (stat.sof) begin
                    cmd.op = OP_SOF;
                    if (stat.phase != PH_IDLE) begin
                        cmd.emit = 1'b1;
                        cmd.kind = KIND_TRUNC;
                        cmd.last = stat.is_q;
                        ret_next = ST_EXEC;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_EXEC: begin
                state_next = ST_IN;
                case (stat.phase)
                    PH_HEADER: begin
                        if (stat.pos < HDR_DIM_POS && !stat.magic_ok) begin
                            cmd.op = OP_GO_IDLE;
                            cmd.emit = 1'b1;
                            cmd.kind = KIND_BAD_MAGIC;
                            ret_next = ST_IN;
                            state_next = ST_OUT;
                        end else if (stat.pos == HDR_LAST_POS) begin
                            cmd.op = OP_MUL;
                            state_next = ST_HCHK;
                        end else begin
                            cmd.op = OP_HDR;
                        end
                    end
                    PH_OPCODE: begin
                        case (stat.cls)
                            CL_PAYLOAD: cmd.op = OP_SET_OP;
                            CL_INDEX: begin
                                cmd.op = OP_RD_IDX;
                                state_next = ST_IDX;
                            end
                            CL_DIFF: begin
                                cmd.op = OP_PUT;
                                cmd.src = SRC_DIFF;
                                cmd.emit = 1'b1;
                                ret_next = ST_IN;
                                state_next = ST_OUT;
                            end
                            default: begin
                                cmd.op = OP_RUN_START;
                                state_next = ST_RUN;
                            end
                        endcase
                    end
                    PH_PAYLOAD: begin
                        if (stat.pay_done) begin
                            cmd.op = OP_PUT;
                            cmd.src = SRC_PAYLOAD;
                            cmd.emit = 1'b1;
                            ret_next = ST_IN;
                            state_next = ST_OUT;
                        end else begin
                            cmd.op = OP_PAY_SHIFT;
                        end
                    end
                    PH_END: begin
                        cmd.op = OP_END_STEP;
                        if (stat.end_done) begin
                            cmd.emit = 1'b1;
                            cmd.kind = stat.end_bad ? KIND_END_BAD : KIND_END_OK;
                            ret_next = ST_IN;
                            state_next = ST_OUT;
                        end
                    end
                    default: cmd.op = OP_NONE;
                endcase
            end
            ST_HCHK: begin
                cmd.emit = 1'b1;
                if (stat.dims_bad) begin
                    cmd.op = OP_GO_IDLE;
                    cmd.kind = KIND_BAD_DIMS;
                end else begin
                    cmd.op = OP_HDR_OK;
                    cmd.kind = KIND_HDR_OK;
                end
                ret_next = ST_IN;
                state_next = ST_OUT;
            end
            ST_IDX: begin
                cmd.op = OP_PUT;
                cmd.src = SRC_INDEX;
                cmd.emit = 1'b1;
                ret_next = ST_IN;
                state_next = ST_OUT;
            end
            ST_RUN: begin
                cmd.emit = 1'b1;
                state_next = ST_OUT;
                if (stat.left_zero) begin
                    cmd.op = OP_GO_IDLE;
                    cmd.kind = KIND_RUN_OVF;
                    ret_next = ST_IN;
                end else begin
                    cmd.op = OP_PUT;
                    cmd.src = SRC_RUN;
                    cmd.last = stat.run_last;
                    ret_next = stat.run_last ? ST_IN : ST_RUN;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ret_reg;
                end
            end
            default: state_next = ST_IN;
        endcase
    end
endmodule

FILE: hw/rtl/qoi_image_stream_decoder_core.sv
// QOI stream decoder top level: byte input, one result word at a time on the output.
// Depends on qoid_pkg, qoid_ctrl, qoid_dp (with qoid_ram).
//
// Decodes a QOI file fed one byte per word into header, pixel and status results.
// A byte that produces no result passes through accept, start-of-file check and
// decode; each result then sits in the output register until taken. An INDEX
// chunk passes through ST_IDX for the registered read of the color index memory,
// the last header byte starts the width-by-height multiply and passes through ST_HCHK
// to check its registered result, and a run emits its pixels one at a time, each
// held until taken. Input is not accepted while a result is held or a run is being emitted.
module qoi_image_stream_decoder_core #(
    parameter int INDEX_ENTRIES = qoid_pkg::INDEX_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_alpha,
    output logic        m_last,
    output logic [31:0] m_image_width,
    output logic [31:0] m_image_height,
    output logic [7:0]  m_channel_count,
    output logic [7:0]  m_color_space
);
    import qoid_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    qoid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    qoid_dp #(
        .INDEX_ENTRIES(INDEX_ENTRIES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_data_byte     (s_data_byte),
        .s_start_of_file (s_start_of_file),
        .cmd             (cmd),
        .stat            (stat),
        .m_kind          (m_kind),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_alpha         (m_alpha),
        .m_last          (m_last),
        .m_image_width   (m_image_width),
        .m_image_height  (m_image_height),
        .m_channel_count (m_channel_count),
        .m_color_space   (m_color_space)
    );
endmodule

FILE: hw/rtl/qoid_checker.sv
// Port-level checks for the QOI stream decoder, bound to the top level.
// Depends on qoid_pkg and qoi_image_stream_decoder_core.
module qoid_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_kind,
    input logic [7:0]  m_red,
    input logic [7:0]  m_green,
    input logic [7:0]  m_blue,
    input logic [7:0]  m_alpha,
    input logic        m_last,
    input logic [31:0] m_image_width,
    input logic [31:0] m_image_height
);
    import qoid_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_red) && $stable(m_last))
        else $error("result word changed while stalled");

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_color_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_PIXEL |->
            m_red == 8'd0 && m_green == 8'd0 && m_blue == 8'd0 && m_alpha == 8'd0)
        else $error("color on a non-pixel result");

    a_dims_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_HDR_OK |-> m_image_width == 32'd0 && m_image_height == 32'd0)
        else $error("header values on a non-header result");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_PIXEL && m_kind != KIND_TRUNC |-> m_last)
        else $error("status result not marked last");
endmodule

bind qoi_image_stream_decoder_core qoid_checker u_qoid_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_kind         (m_kind),
    .m_red          (m_red),
    .m_green        (m_green),
    .m_blue         (m_blue),
    .m_alpha        (m_alpha),
    .m_last         (m_last),
    .m_image_width  (m_image_width),
    .m_image_height (m_image_height)
);
